// File: rtl/parachute_deploy_controller_top_defines.svh
// ---------------------------------------------------------------------------
// parachute deploy controller assertion macros
// concurrent checks clocked on clk, held off while arst_n is low
// ---------------------------------------------------------------------------
`ifndef PARACHUTE_DEPLOY_CONTROLLER_TOP_DEFINES_SVH
`define PARACHUTE_DEPLOY_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define PDC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdc assertion failed");

// next-cycle implication
`define PDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdc assertion failed");

`else

`define PDC_ASSERT_IMPL(lbl, ante, cons)
`define PDC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/pdc_pkg.sv
// ---------------------------------------------------------------------------
// pdc_pkg
// types and constants shared by the parachute deploy controller
// ---------------------------------------------------------------------------
package pdc_pkg;

	localparam int unsigned PRESS_W = 17;
	localparam int unsigned TICKS_W = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// largest step between samples that is not a spike, in pascal
	localparam logic [PRESS_W:0] SPIKE_LIMIT_PA = 18'd500;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GROUND_PRESSURE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MARGIN       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DESCENT_THRESHOLD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ON_TICKS    = 2'd3;

	localparam logic [PRESS_W-1:0] GROUND_PRESSURE_RST   = 17'd101325;
	localparam logic [PRESS_W-1:0] OPEN_MARGIN_RST       = 17'd0;
	localparam logic [PRESS_W-1:0] DESCENT_THRESHOLD_RST = 17'd100;
	localparam logic [TICKS_W-1:0] MOTOR_ON_TICKS_RST    = 16'd1000;

	// operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef enum logic [1:0] {
		PH_ASCENDING  = 2'd0,
		PH_DESCENDING = 2'd1,
		PH_OPENING    = 2'd2,
		PH_DONE       = 2'd3
	} phase_t;

	typedef struct packed {
		logic [PRESS_W-1:0] ground_pressure;
		logic [PRESS_W-1:0] open_margin;
		logic [PRESS_W-1:0] descent_threshold;
		logic [TICKS_W-1:0] motor_on_ticks;
	} cfg_t;

	typedef struct packed {
		logic               operation;
		logic               sample_valid;
		logic [PRESS_W-1:0] pressure;
	} item_t;

	typedef struct packed {
		phase_t phase;
		logic   motor_drive;
		logic   sample_rejected;
	} result_t;

	typedef struct packed {
		phase_t phase;
		logic   primed;
		logic   motor_active;
	} status_t;

endpackage

// File: rtl/pdc_item_if.sv
// ---------------------------------------------------------------------------
// pdc_item_if
// input channel: pressure samples and time ticks
// ---------------------------------------------------------------------------
interface pdc_item_if import pdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic               sample_valid;
	logic [PRESS_W-1:0] pressure;

	modport source (output valid, output operation, output sample_valid, output pressure,
		input ready);
	modport sink (input valid, input operation, input sample_valid, input pressure,
		output ready);
endinterface

// File: rtl/pdc_result_if.sv
// ---------------------------------------------------------------------------
// pdc_result_if
// output channel: phase, motor drive and rejection flag
// ---------------------------------------------------------------------------
interface pdc_result_if import pdc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] phase;
	logic       motor_drive;
	logic       sample_rejected;

	modport source (output valid, output phase, output motor_drive, output sample_rejected,
		input ready);
	modport sink (input valid, input phase, input motor_drive, input sample_rejected,
		output ready);
endinterface

// File: rtl/parachute_deploy_controller_top.sv
// a result word is registered in the output buffer before it is offered
// throughput: one item per cycle while the buffer has space; the state update is
// a single compare/add pass; the two-word result buffer holds words during stalls
// reset: arst_n low clears phase to ascending, pressures, motor timer and buffer;
// registers return to ground 101325, margin 0, threshold 100, motor ticks 1000
// ---------------------------------------------------------------------------
// parachute_deploy_controller_top
// barometric parachute release controller
// ---------------------------------------------------------------------------
`include "parachute_deploy_controller_top_defines.svh"

module parachute_deploy_controller_top import pdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PRESS_W-1:0]   cfg_wdata,
	pdc_item_if.sink             item,
	pdc_result_if.source         result
);

	cfg_t    cfg;
	item_t   item_word;
	result_t res_word;
	result_t head_word;
	status_t status;
	logic    space;
	logic    accept;

	assign item_word.operation    = item.operation;
	assign item_word.sample_valid = item.sample_valid;
	assign item_word.pressure     = item.pressure;
	assign item.ready             = space;
	assign accept                 = item.valid && space;

	pdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pdc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.item   (item_word),
		.res    (res_word),
		.status (status)
	);

	pdc_out_buf u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_word  (res_word),
		.space      (space),
		.head_valid (result.valid),
		.head_word  (head_word),
		.pop_ready  (result.ready)
	);

	assign result.phase           = head_word.phase;
	assign result.motor_drive     = head_word.motor_drive;
	assign result.sample_rejected = head_word.sample_rejected;

	// done is final
	`PDC_ASSERT_NEXT(a_done_sticky, status.phase == PH_DONE, status.phase == PH_DONE)
	// the motor only runs once the release has fired
	`PDC_ASSERT_IMPL(a_motor_in_done, status.motor_active, status.phase == PH_DONE)
	// leaving ascending needs a primed pressure history
	`PDC_ASSERT_IMPL(a_phase_needs_prime, status.phase != PH_ASCENDING, status.primed)
	// a word showing the motor driven must carry the done phase
	`PDC_ASSERT_IMPL(a_word_motor_done, result.valid && result.motor_drive,
		result.phase == PH_DONE)

endmodule

// File: rtl/pdc_cfg_regs.sv
// ---------------------------------------------------------------------------
// pdc_cfg_regs
// configuration register file with write-only port
// ---------------------------------------------------------------------------
module pdc_cfg_regs import pdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PRESS_W-1:0]   cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ground_pressure   <= GROUND_PRESSURE_RST;
			cfg_q.open_margin       <= OPEN_MARGIN_RST;
			cfg_q.descent_threshold <= DESCENT_THRESHOLD_RST;
			cfg_q.motor_on_ticks    <= MOTOR_ON_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GROUND_PRESSURE:   cfg_q.ground_pressure   <= cfg_wdata;
				CFG_OPEN_MARGIN:       cfg_q.open_margin       <= cfg_wdata;
				CFG_DESCENT_THRESHOLD: cfg_q.descent_threshold <= cfg_wdata;
				CFG_MOTOR_ON_TICKS:    cfg_q.motor_on_ticks    <= cfg_wdata[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/pdc_core.sv
// ---------------------------------------------------------------------------
// pdc_core
// flight phase tracking, spike filter and release motor timer
// ---------------------------------------------------------------------------
module pdc_core import pdc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    accept,
	input  item_t   item,
	output result_t res,
	output status_t status
);

	phase_t             phase_q, phase_d;
	logic               primed_q, primed_d;
	logic [PRESS_W-1:0] last_q, last_d;
	logic [PRESS_W-1:0] min_q, min_d;
	logic               motor_q, motor_d;
	logic [TICKS_W-1:0] remain_q, remain_d;
	logic               rejected_d;

	logic [PRESS_W-1:0] last_eff;
	logic [PRESS_W-1:0] min_eff;
	logic signed [PRESS_W:0] diff;
	logic [PRESS_W:0]        abs_diff;
	logic signed [PRESS_W:0] rise;
	logic signed [PRESS_W:0] open_level;
	logic                    is_spike;

	// an unprimed sample acts as its own last and minimum
	assign last_eff   = primed_q ? last_q : item.pressure;
	assign min_eff    = primed_q ? min_q : item.pressure;
	assign diff       = $signed({1'b0, item.pressure}) - $signed({1'b0, last_eff});
	assign abs_diff   = diff[PRESS_W] ? unsigned'(-diff) : unsigned'(diff);
	assign is_spike   = abs_diff > SPIKE_LIMIT_PA;
	assign rise       = $signed({1'b0, item.pressure}) - $signed({1'b0, min_eff});
	assign open_level = $signed({1'b0, cfg.ground_pressure}) -
		$signed({1'b0, cfg.open_margin});

	// next state
	always_comb begin
		phase_d    = phase_q;
		primed_d   = primed_q;
		last_d     = last_q;
		min_d      = min_q;
		motor_d    = motor_q;
		remain_d   = remain_q;
		rejected_d = 1'b0;
		if (accept) begin
			if (item.operation == OP_TICK) begin
				if (motor_q) begin
					if (remain_q <= 16'd1) begin
						remain_d = '0;
						motor_d  = 1'b0;
					end else begin
						remain_d = remain_q - 16'd1;
					end
				end
			end else if (!item.sample_valid || phase_q == PH_DONE) begin
				rejected_d = 1'b1;
			end else begin
				primed_d = 1'b1;
				last_d   = item.pressure;
				if (is_spike) begin
					rejected_d = 1'b1;
					min_d      = min_eff;
				end else begin
					unique case (phase_q)
						PH_ASCENDING: begin
							if (rise > $signed({1'b0, cfg.descent_threshold}))
								phase_d = PH_DESCENDING;
						end
						PH_DESCENDING: begin
							if (item.pressure < min_eff)
								phase_d = PH_ASCENDING;
							else if ($signed({1'b0, item.pressure}) > open_level)
								phase_d = PH_OPENING;
						end
						PH_OPENING: begin
							motor_d  = 1'b1;
							remain_d = cfg.motor_on_ticks;
							phase_d  = PH_DONE;
						end
						PH_DONE: ;
						default: ;
					endcase
					min_d = (item.pressure < min_eff) ? item.pressure : min_eff;
				end
			end
		end
	end

	// outputs
	always_comb begin
		res.phase           = phase_d;
		res.motor_drive     = motor_d;
		res.sample_rejected = rejected_d;
		status.phase        = phase_q;
		status.primed       = primed_q;
		status.motor_active = motor_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ASCENDING;
			primed_q <= 1'b0;
			last_q   <= '0;
			min_q    <= '0;
			motor_q  <= 1'b0;
			remain_q <= '0;
		end else begin
			phase_q  <= phase_d;
			primed_q <= primed_d;
			last_q   <= last_d;
			min_q    <= min_d;
			motor_q  <= motor_d;
			remain_q <= remain_d;
		end
	end

endmodule

// File: rtl/pdc_out_buf.sv
// ---------------------------------------------------------------------------
// pdc_out_buf
// two-word result buffer: result register plus skid register
// ---------------------------------------------------------------------------
module pdc_out_buf import pdc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_word,
	output logic    space,
	output logic    head_valid,
	output result_t head_word,
	input  logic    pop_ready
);

	logic    head_v_q;
	logic    skid_v_q;
	result_t head_q;
	result_t skid_q;
	logic    pop;

	assign pop        = head_v_q && pop_ready;
	assign space      = !skid_v_q;
	assign head_valid = head_v_q;
	assign head_word  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			if (head_v_q)
				skid_v_q <= 1'b1;
			else
				head_v_q <= 1'b1;
		end
	end

	// payload moves, no reset needed
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q)
				head_q <= skid_q;
			else if (push)
				head_q <= push_word;
		end else if (push) begin
			if (head_v_q)
				skid_q <= push_word;
			else
				head_q <= push_word;
		end
	end

endmodule

// File: sim/pdc_flight_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdc_flight_checker
// follows register writes and accepted words on both channels, works out the
// flight phase, motor and rejection flag for every sample or tick and checks
// each result word against the oldest outstanding prediction
// ---------------------------------------------------------------------------
module pdc_flight_checker import pdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PRESS_W-1:0]   cfg_wdata,
	pdc_item_if                  item,
	pdc_result_if                result,
	output int unsigned          words_pending,
	output int unsigned          words_checked,
	output int unsigned          fail_count,
	output logic [3:0]           phases_reached
);

	// register copies
	logic [PRESS_W-1:0] ground_p;
	logic [PRESS_W-1:0] margin_p;
	logic [PRESS_W-1:0] rise_limit;
	logic [TICKS_W-1:0] release_ticks;

	// flight state
	phase_t             flight;
	logic               primed;
	logic [PRESS_W-1:0] last_p;
	logic [PRESS_W-1:0] min_p;
	logic               motor_on;
	logic [TICKS_W-1:0] motor_left;

	result_t            flight_words[$];

	function automatic result_t next_flight_word(input logic op, input logic ok,
		input logic [PRESS_W-1:0] p);
		result_t w;
		logic    rej;
		int      p_jump;
		int      open_level;
		rej = 1'b0;
		if (op == OP_TICK) begin
			if (motor_on) begin
				if (motor_left <= 1) begin
					motor_left = '0;
					motor_on = 1'b0;
				end else begin
					motor_left = motor_left - 1'b1;
				end
			end
		end else if (!ok || flight == PH_DONE) begin
			rej = 1'b1;
		end else begin
			if (!primed) begin
				last_p = p;
				min_p = p;
				primed = 1'b1;
			end
			p_jump = int'(p) - int'(last_p);
			if (p_jump < 0)
				p_jump = -p_jump;
			last_p = p;
			if (p_jump > int'(SPIKE_LIMIT_PA)) begin
				rej = 1'b1;
			end else begin
				// opening level may go below zero
				open_level = int'(ground_p) - int'(margin_p);
				case (flight)
					PH_ASCENDING: begin
						if (int'(p) - int'(min_p) > int'(rise_limit))
							flight = PH_DESCENDING;
					end
					PH_DESCENDING: begin
						if (p < min_p)
							flight = PH_ASCENDING;
						else if (int'(p) > open_level)
							flight = PH_OPENING;
					end
					default: begin
						motor_on = 1'b1;
						motor_left = release_ticks;
						flight = PH_DONE;
					end
				endcase
				if (p < min_p)
					min_p = p;
			end
		end
		w.phase = flight;
		w.motor_drive = motor_on;
		w.sample_rejected = rej;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			ground_p = GROUND_PRESSURE_RST;
			margin_p = OPEN_MARGIN_RST;
			rise_limit = DESCENT_THRESHOLD_RST;
			release_ticks = MOTOR_ON_TICKS_RST;
			flight = PH_ASCENDING;
			primed = 1'b0;
			last_p = '0;
			min_p = '0;
			motor_on = 1'b0;
			motor_left = '0;
			flight_words.delete();
			words_pending = 0;
			words_checked = 0;
			fail_count = 0;
			phases_reached = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GROUND_PRESSURE:   ground_p = cfg_wdata;
					CFG_OPEN_MARGIN:       margin_p = cfg_wdata;
					CFG_DESCENT_THRESHOLD: rise_limit = cfg_wdata;
					CFG_MOTOR_ON_TICKS:    release_ticks = cfg_wdata[TICKS_W-1:0];
					default: ;
				endcase
			end
			// the word for an item accepted now is registered first, so it never shows up in this same cycle
			if (result.valid && result.ready) begin
				got.phase = phase_t'(result.phase);
				got.motor_drive = result.motor_drive;
				got.sample_rejected = result.sample_rejected;
				words_checked++;
				if (flight_words.size() == 0) begin
					$error("result word with nothing outstanding: phase %0d", got.phase);
					fail_count++;
				end else begin
					want = flight_words.pop_front();
					phases_reached[want.phase] = 1'b1;
					if (got.phase !== want.phase) begin
						$error("phase: expected %0d, got %0d", want.phase, result.phase);
						fail_count++;
					end
					if (got.motor_drive !== want.motor_drive) begin
						$error("motor_drive: expected %0b, got %0b", want.motor_drive,
							got.motor_drive);
						fail_count++;
					end
					if (got.sample_rejected !== want.sample_rejected) begin
						$error("sample_rejected: expected %0b, got %0b",
							want.sample_rejected, got.sample_rejected);
						fail_count++;
					end
				end
			end
			if (item.valid && item.ready)
				flight_words.push_back(next_flight_word(item.operation, item.sample_valid,
					item.pressure));
			words_pending = flight_words.size();
		end
	end

endmodule

// File: sim/parachute_deploy_controller_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// parachute_deploy_controller_top_tb
// drives a directed climb and fall with spikes and invalid readings, then
// random pressure walks under several register settings, and finally a
// release with the motor countdown; random gaps on both channels and one
// long output stall
// ---------------------------------------------------------------------------
module parachute_deploy_controller_top_tb;
	import pdc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 200;
	localparam int WALK_CEIL   = 125000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PRESS_W-1:0]   cfg_wdata;

	int unsigned          words_pending;
	int unsigned          words_checked;
	int unsigned          fail_count;
	logic [3:0]           phases_reached;

	int                   cycle_count;
	int                   walk_p;
	int                   samples_sent;
	int                   ticks_sent;
	bit                   steady_feed;

	pdc_item_if   item_ch ();
	pdc_result_if result_ch ();

	parachute_deploy_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	pdc_flight_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.item           (item_ch),
		.result         (result_ch),
		.words_pending  (words_pending),
		.words_checked  (words_checked),
		.fail_count     (fail_count),
		.phases_reached (phases_reached)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("parachute_deploy_controller_top_tb: FAIL");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(8, 30));
	endfunction

	// output side: bursts of ready, gaps, and one long hold-off
	initial begin : sink_pacing
		int  run;
		int  idle;
		bit  held;
		held = 1'b0;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			run = $urandom_range(1, 24);
			repeat (run) begin
				@(negedge clk);
				result_ch.ready <= 1'b1;
			end
			idle = pause_len();
			if (!held && words_checked >= 120) begin
				held = 1'b1;
				idle = LONG_HOLD;
			end
			repeat (idle) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic op, input logic ok, input logic [PRESS_W-1:0] p);
		int idle;
		idle = steady_feed ? 0 : pause_len();
		repeat (idle) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.sample_valid <= ok;
		item_ch.pressure <= p;
		do
			@(posedge clk);
		while (item_ch.valid !== 1'b1 || item_ch.ready !== 1'b1);
		if (op == OP_TICK)
			ticks_sent++;
		else
			samples_sent++;
	endtask

	// drop valid and wait until every word has come back
	task automatic await_idle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (words_pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic load_profile(input logic [PRESS_W-1:0] ground, input logic [PRESS_W-1:0] margin,
		input logic [PRESS_W-1:0] rise, input logic [TICKS_W-1:0] ticks);
		await_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GROUND_PRESSURE;
		cfg_wdata <= ground;
		@(negedge clk);
		cfg_index <= CFG_OPEN_MARGIN;
		cfg_wdata <= margin;
		@(negedge clk);
		cfg_index <= CFG_DESCENT_THRESHOLD;
		cfg_wdata <= rise;
		@(negedge clk);
		cfg_index <= CFG_MOTOR_ON_TICKS;
		cfg_wdata <= {1'b0, ticks};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// pressure walk drifting downwards (climbing), with ticks, bad readings and spikes
	task automatic fly_random(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			if (i % 32 == 0)
				steady_feed = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 12) begin
				send_item(OP_TICK, 1'($urandom), PRESS_W'($urandom));
			end else if (r < 17) begin
				send_item(OP_SAMPLE, 1'b0, PRESS_W'($urandom));
			end else if (r < 21) begin
				send_item(OP_SAMPLE, 1'b1, PRESS_W'($urandom));
			end else begin
				walk_p = walk_p + int'($urandom_range(0, 850)) - 470;
				if (walk_p < 0)
					walk_p = 0;
				if (walk_p > WALK_CEIL)
					walk_p = WALK_CEIL;
				send_item(OP_SAMPLE, 1'b1, PRESS_W'(walk_p));
			end
		end
		steady_feed = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_GROUND_PRESSURE;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_SAMPLE;
		item_ch.sample_valid = 1'b0;
		item_ch.pressure = '0;
		cycle_count = 0;
		samples_sent = 0;
		ticks_sent = 0;
		steady_feed = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, edges of the spike limit and of the threshold
		send_item(OP_TICK, 1'b1, '0);
		send_item(OP_SAMPLE, 1'b0, 17'd131071);
		send_item(OP_SAMPLE, 1'b0, 17'd0);
		send_item(OP_SAMPLE, 1'b1, 17'd100000);
		send_item(OP_SAMPLE, 1'b1, 17'd100501);
		send_item(OP_SAMPLE, 1'b1, 17'd100001);
		send_item(OP_SAMPLE, 1'b1, 17'd99501);
		send_item(OP_SAMPLE, 1'b1, 17'd99602);
		send_item(OP_SAMPLE, 1'b1, 17'd99500);
		send_item(OP_SAMPLE, 1'b1, 17'd99600);
		send_item(OP_SAMPLE, 1'b1, 17'd0);
		send_item(OP_SAMPLE, 1'b1, 17'd131071);
		send_item(OP_SAMPLE, 1'b1, 17'd99550);
		send_item(OP_SAMPLE, 1'b1, 17'd99650);
		send_item(OP_SAMPLE, 1'b1, 17'd99500);
		send_item(OP_TICK, 1'b0, 17'd131071);
		send_item(OP_SAMPLE, 1'b0, 17'd99000);
		send_item(OP_SAMPLE, 1'b1, 17'd99499);
		walk_p = 99499;

		// opening level kept out of reach of the walk until the last stage
		load_profile(17'd131071, 17'd0, 17'd0, 16'd65535);
		fly_random(160);
		load_profile(17'd131071, PRESS_W'($urandom_range(0, 5071)),
			PRESS_W'($urandom_range(1, 600)), 16'd0);
		fly_random(160);
		load_profile(PRESS_W'($urandom_range(126000, 131071)), 17'd0, 17'd131071,
			TICKS_W'($urandom_range(1, 65535)));
		fly_random(160);

		// negative opening level: descend, open, release, then count the motor down
		load_profile(17'd0, 17'd131071, 17'd200, TICKS_W'($urandom_range(0, 40)));
		repeat (6) begin
			walk_p = walk_p + 150;
			send_item(OP_SAMPLE, 1'b1, PRESS_W'(walk_p));
		end
		for (int i = 0; i < 64; i++) begin
			if (i % 4 == 3)
				send_item(OP_SAMPLE, 1'($urandom), PRESS_W'($urandom));
			else
				send_item(OP_TICK, 1'($urandom), PRESS_W'($urandom));
		end

		await_idle();
		repeat (4) @(negedge clk);
		$display("covered %0d samples and %0d ticks under five register settings, %0d words checked",
			samples_sent, ticks_sent, words_checked);
		$display("phases reached (done, opening, descending, ascending): %b", phases_reached);
		if (fail_count == 0)
			$display("parachute_deploy_controller_top_tb: PASS");
		else
			$display("parachute_deploy_controller_top_tb: FAIL");
		$finish;
	end

endmodule
